// File: sv/lfcb_pkg.sv
// Shared constants for the lowpass-feedback comb bank: comb count, comb lengths,
// register indexes, gain reset values and port widths.
// No dependencies.
`default_nettype none

package lfcb_pkg;

   localparam int NUM_COMBS        = 8;
   localparam int COMB_W           = 3;
   localparam int LEN_W            = 11;
   localparam int GAIN_W           = 8;
   localparam int IO_W             = 32;
   localparam int CSR_IDX_W        = 1;
   localparam int DELAY_DEPTH_DEF  = 2048;
   localparam int SAMPLE_WIDTH_DEF = 32;

   localparam logic [GAIN_W-1:0] DAMP_RESET = 8'd192;
   localparam logic [GAIN_W-1:0] FB_RESET   = 8'd224;

   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK = 1'd1;

   // Delay of each comb in samples; combs 0..3 feed the left side, 4..7 the right.
   localparam logic [LEN_W-1:0] COMB_LEN [NUM_COMBS] = '{
      11'd1557, 11'd1617, 11'd1491, 11'd1422,
      11'd1277, 11'd1356, 11'd1188, 11'd1116
   };

endpackage

`default_nettype wire

// File: sv/lowpass_feedback_comb_bank.sv
// Eight lowpass-feedback comb filters sharing one delay memory, mono in, stereo out.
// Depends on lfcb_pkg.
`default_nettype none

// Channel   Direction  Ports                              Beat
// req       in         req_valid/req_ready, req_sample_in one mono sample
// rsp       out        rsp_valid/rsp_ready, rsp_left_out,  one stereo pair
//                      rsp_right_out
// csr       in         csr_wr_en, csr_index, csr_wdata    one gain register write
//
// An item runs from the accepting edge to the edge that loads the result register:
// eight delay-memory reads at one per cycle (the memory's single read port sets this),
// then the four pipeline stages until the last comb's write-back, then a close-out
// step. The next sample is taken in the cycle after the result loads,
// even while that result still waits for rsp_ready.
// After reset the delay memory is cleared one word a cycle, all 8 * 2**clog2(DELAY_DEPTH)
// words (16384 at the default depth); req_ready stays low until that ends.
// A stalled result holds the block only at the close-out step, with all its work done.

module lowpass_feedback_comb_bank #(
   parameter int DELAY_DEPTH  = lfcb_pkg::DELAY_DEPTH_DEF,
   parameter int SAMPLE_WIDTH = lfcb_pkg::SAMPLE_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic signed [lfcb_pkg::IO_W-1:0]    req_sample_in,

   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic signed [lfcb_pkg::IO_W-1:0]    rsp_left_out,
   output      logic signed [lfcb_pkg::IO_W-1:0]    rsp_right_out,

   input  wire logic                                csr_wr_en,
   input  wire logic [lfcb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [lfcb_pkg::GAIN_W-1:0]         csr_wdata
);
   import lfcb_pkg::*;

   localparam int W         = SAMPLE_WIDTH;
   localparam int PTR_W     = $clog2(DELAY_DEPTH);
   localparam int ADDR_W    = COMB_W + PTR_W;
   localparam int MEM_DEPTH = NUM_COMBS << PTR_W;
   localparam int CNT_W     = COMB_W + 1;

   localparam logic [PTR_W:0]   DEPTH_C  = (PTR_W+1)'(DELAY_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DELAY_DEPTH - 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   // Control state.
   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [PTR_W-1:0]  ptr_ff;
   logic [GAIN_W-1:0] damp_ff, fb_ff;
   logic              rsp_valid_ff;

   // Item state.
   logic signed [W-1:0] x_ff, left_ff, right_ff;
   logic signed [W-1:0] rsp_left_ff, rsp_right_ff;
   logic signed [W-1:0] lp_ff [NUM_COMBS];

   // Delay memory.
   logic signed [W-1:0] mem [MEM_DEPTH];
   logic signed [W-1:0] mem_q_ff;
   logic [ADDR_W-1:0]   rd_addr, wr_addr;
   logic                wr_en;
   logic signed [W-1:0] wr_data;

   // Pipeline stages.
   logic                 s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic [COMB_W-1:0]    s1_k_ff, s2_k_ff, s3_k_ff, s4_k_ff;
   logic [PTR_W-1:0]     s1_wp_ff, s2_wp_ff, s3_wp_ff, s4_wp_ff;
   logic signed [W+8:0]  pa_ff, pb_ff, pf_ff;
   logic signed [W+8:0]  pa_in, pb_in, pf_in;
   logic signed [W+9:0]  mix_sum;
   logic signed [W-1:0]  z_ff, z_in;
   logic signed [W-1:0]  quarter;

   logic              accept, issue, run_done;
   logic [COMB_W-1:0] issue_k;
   logic [PTR_W:0]    wp_sum;
   logic [PTR_W-1:0]  wp_in;

   assign accept   = req_valid && req_ready;
   assign issue    = (state_ff == ST_RUN) && !cnt_ff[COMB_W];
   assign issue_k  = cnt_ff[COMB_W-1:0];
   assign run_done = (state_ff == ST_RUN) && cnt_ff[COMB_W]
                     && !(s1_v_ff || s2_v_ff || s3_v_ff || s4_v_ff)
                     && (!rsp_valid_ff || rsp_ready);

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = IO_W'(rsp_left_ff);
   assign rsp_right_out = IO_W'(rsp_right_ff);

   // Write address of the comb being issued: pointer plus comb delay, modulo depth.
   assign wp_sum = {1'b0, ptr_ff} + (PTR_W+1)'(COMB_LEN[issue_k]);
   assign wp_in  = (wp_sum >= DEPTH_C) ? PTR_W'(wp_sum - DEPTH_C) : wp_sum[PTR_W-1:0];

   // Stage 1 arithmetic: lowpass products; the complement of damping is 255 - damping.
   assign quarter = mem_q_ff >>> 2;
   assign pa_in   = $signed({1'b0, damp_ff}) * mem_q_ff;
   assign pb_in   = $signed({1'b0, ~damp_ff}) * lp_ff[s1_k_ff];

   // Stage 2: new lowpass state, floor shift by 8 then wrap to the sample width.
   assign mix_sum = (W+10)'(pa_ff) + (W+10)'(pb_ff);
   assign z_in    = mix_sum[W+7:8];

   // Stage 3: feedback product.
   assign pf_in = z_ff * $signed({1'b0, fb_ff});

   // Memory port selection: clearing pass after reset, else the write-back stage.
   assign rd_addr = {issue_k, ptr_ff};
   assign wr_en   = (state_ff == ST_CLEAR) || s4_v_ff;
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_ff : {s4_k_ff, s4_wp_ff};
   assign wr_data = (state_ff == ST_CLEAR) ? '0 : x_ff + pf_ff[W+7:8];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (run_done) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         damp_ff      <= DAMP_RESET;
         fb_ff        <= FB_RESET;
         rsp_valid_ff <= 1'b0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         s4_v_ff      <= 1'b0;
         for (int i = 0; i < NUM_COMBS; i++) begin
            lp_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;

         if (csr_wr_en) begin
            case (csr_index)
               CSR_DAMPING:  damp_ff <= csr_wdata;
               CSR_FEEDBACK: fb_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end

         if (accept) cnt_ff <= '0;
         else if (issue) cnt_ff <= cnt_ff + 1'b1;

         s1_v_ff <= issue;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;

         if (s2_v_ff) lp_ff[s2_k_ff] <= z_in;

         if (run_done) begin
            rsp_valid_ff <= 1'b1;
            ptr_ff       <= (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers, no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff     <= req_sample_in[W-1:0];
         left_ff  <= req_sample_in[W-1:0];
         right_ff <= req_sample_in[W-1:0];
      end else if (s1_v_ff) begin
         // Combs in the lower half go left, the upper half right.
         if (!s1_k_ff[COMB_W-1]) left_ff  <= left_ff + quarter;
         else                    right_ff <= right_ff + quarter;
      end

      s1_k_ff  <= issue_k;
      s1_wp_ff <= wp_in;
      s2_k_ff  <= s1_k_ff;
      s2_wp_ff <= s1_wp_ff;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      s3_k_ff  <= s2_k_ff;
      s3_wp_ff <= s2_wp_ff;
      z_ff     <= z_in;
      s4_k_ff  <= s3_k_ff;
      s4_wp_ff <= s3_wp_ff;
      pf_ff    <= pf_in;

      if (run_done) begin
         rsp_left_ff  <= left_ff;
         rsp_right_ff <= right_ff;
      end
   end

endmodule

`default_nettype wire

// File: sv/lfcb_checker.sv
// Port-level checks for the lowpass-feedback comb bank, bound to the top level.
// Depends on lfcb_pkg and lowpass_feedback_comb_bank.
`default_nettype none

module lfcb_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic signed [lfcb_pkg::IO_W-1:0]    req_sample_in,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic signed [lfcb_pkg::IO_W-1:0]    rsp_left_out,
   input wire logic signed [lfcb_pkg::IO_W-1:0]    rsp_right_out
);
   import lfcb_pkg::*;

   // A waiting input beat holds its value.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_sample_in))
      else $error("input beat changed while stalled");

   // A waiting result beat holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_out)
                                  && $stable(rsp_right_out))
      else $error("result beat changed while stalled");

   // After a sample is taken the block stays busy through the comb sweep.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##12 !req_ready)
      else $error("input taken again before the comb sweep finished");

   // A new result appears only as the block returns to idle.
   a_rsp_with_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $rose(req_ready))
      else $error("result appeared without an item finishing");

   // The first cycle after reset is spent clearing, with nothing offered.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("block active before the delay memory was cleared");

endmodule

bind lowpass_feedback_comb_bank lfcb_checker u_lfcb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_sample_in (req_sample_in),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_left_out  (rsp_left_out),
   .rsp_right_out (rsp_right_out)
);

`default_nettype wire

// File: verif/tb_lowpass_feedback_comb_bank.sv
// Self-checking testbench for lowpass_feedback_comb_bank: mono samples in, stereo pairs out.
// Holds its own comb-bank predictor and a scoreboard class; depends on lfcb_pkg and the RTL.
`timescale 1ns / 1ps

module tb_lowpass_feedback_comb_bank;
   import lfcb_pkg::*;

   localparam int CLK_HALF_NS     = 5;
   localparam int RESET_CYCLES    = 7;
   // Settling time after a drain; a comfortable margin over one sample's processing.
   localparam int SETTLE_CYCLES   = 20;
   localparam int SEGMENT_ITEMS   = 239;
   localparam int NUM_SEGMENTS    = 6;
   localparam int RSP_HOLD_CYCLES = 400;
   // Limit on the whole run, including the memory clear after reset.
   localparam int RUN_LIMIT_NS    = 5_000_000;
   localparam int NUM_EXTREMES    = 13;

   localparam logic signed [IO_W-1:0] EXTREME_SAMPLES [NUM_EXTREMES] = '{
      32'sh0000_0000, 32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0000_0002, 32'shFFFF_FFFE,
      32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFE, 32'sh8000_0001,
      32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0001_0000, 32'shFFFF_0000
   };

   typedef struct packed {
      logic signed [IO_W-1:0] left;
      logic signed [IO_W-1:0] right;
   } stereo_pair_type;

   // Scoreboard: runs the comb bank on every accepted sample and keeps the predicted
   // stereo pairs in order until the block hands them back.
   class comb_bank_scoreboard;
      logic signed [IO_W-1:0]  delay_line [NUM_COMBS][DELAY_DEPTH_DEF];
      logic signed [IO_W-1:0]  lp_state [NUM_COMBS];
      logic [LEN_W-1:0]        rd_ptr;
      logic [GAIN_W-1:0]       damping;
      logic [GAIN_W-1:0]       feedback;
      stereo_pair_type         predicted_pairs [$];
      int                      error_count;

      function new();
         for (int k = 0; k < NUM_COMBS; k++) begin
            lp_state[k] = '0;
            for (int a = 0; a < DELAY_DEPTH_DEF; a++)
               delay_line[k][a] = '0;
         end
         rd_ptr      = '0;
         damping     = DAMP_RESET;
         feedback    = FB_RESET;
         error_count = 0;
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         error_count++;
      endtask

      function void set_gain(logic [CSR_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
         case (idx)
            CSR_DAMPING:  damping  = val;
            CSR_FEEDBACK: feedback = val;
            default: ;
         endcase
      endfunction

      // One sample through all eight combs. Every comb reads at the shared pointer,
      // runs its one-pole lowpass and writes input plus scaled feedback one delay ahead.
      function void take_sample(logic signed [IO_W-1:0] x);
         stereo_pair_type  pair;
         longint           y;
         longint           dmp;
         longint           dmp_c;
         longint           fbk;
         logic [LEN_W-1:0] wr_addr;
         pair.left  = x;
         pair.right = x;
         dmp   = longint'(damping);
         dmp_c = 255 - dmp;
         fbk   = longint'(feedback);
         for (int k = 0; k < NUM_COMBS; k++) begin
            y = longint'(delay_line[k][rd_ptr]);
            // The arithmetic shifts below are floor divisions; the 32-bit targets wrap.
            if (k < NUM_COMBS / 2)
               pair.left = IO_W'(pair.left + (y >>> 2));
            else
               pair.right = IO_W'(pair.right + (y >>> 2));
            lp_state[k] = IO_W'((dmp * y + dmp_c * lp_state[k]) >>> 8);
            wr_addr = rd_ptr + COMB_LEN[k];
            delay_line[k][wr_addr] = IO_W'(x + ((lp_state[k] * fbk) >>> 8));
         end
         rd_ptr = rd_ptr + 1'b1;
         predicted_pairs.push_back(pair);
      endfunction

      task check_pair(logic signed [IO_W-1:0] left, logic signed [IO_W-1:0] right);
         stereo_pair_type want;
         if (predicted_pairs.size() == 0) begin
            report($sformatf("result beat %0d/%0d with no sample outstanding", left, right));
            return;
         end
         want = predicted_pairs.pop_front();
         if (left !== want.left)
            report($sformatf("left_out expected %0d, got %0d", want.left, left));
         if (right !== want.right)
            report($sformatf("right_out expected %0d, got %0d", want.right, right));
      endtask

      function int pending_count();
         return predicted_pairs.size();
      endfunction
   endclass

   // Every input starts at a known value; reset is high from time zero.
   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_ready;
   logic signed [IO_W-1:0] req_sample_in = '0;
   logic                   rsp_valid;
   logic                   rsp_ready     = 1'b0;
   logic signed [IO_W-1:0] rsp_left_out;
   logic signed [IO_W-1:0] rsp_right_out;
   logic                   csr_wr_en     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index     = '0;
   logic [GAIN_W-1:0]      csr_wdata     = '0;

   // Idle rates in percent, changed by the main sequence between segments.
   int unsigned            send_idle_pct = 0;
   int unsigned            rsp_idle_pct  = 0;
   logic                   hold_off_req  = 1'b0;

   comb_bank_scoreboard    sb;

   lowpass_feedback_comb_bank DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_in (req_sample_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #(CLK_HALF_NS) clock = ~clock;

   // Monitor. Everything is sampled at the rising edge, so it sees the values that the
   // edge acts on. A result is checked before the sample of the same edge is predicted,
   // since that result always belongs to an earlier sample.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_pair(rsp_left_out, rsp_right_out);
         if (req_valid && req_ready)
            sb.take_sample(req_sample_in);
         if (csr_wr_en)
            sb.set_gain(csr_index, csr_wdata);
      end
   end

   // Receiver. Each cycle it is ready or not at the current idle rate; once asked it
   // holds ready low for a long stretch so the block backs up and stalls its input.
   initial begin
      logic hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // Overall limit on the run.
   initial begin
      #(RUN_LIMIT_NS);
      $display("FAIL lowpass_feedback_comb_bank");
      $finish;
   end

   // Offers one sample and returns at the edge that accepts it, with valid still high,
   // so a back-to-back sample keeps valid up without a glitch. Idle cycles go first.
   task automatic send_sample(input logic signed [IO_W-1:0] s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      while (sb.pending_count() != 0) @(posedge clock);
   endtask

   // Both gain registers, one write beat each; the block must be idle.
   task automatic write_gains(input logic [GAIN_W-1:0] dmp, input logic [GAIN_W-1:0] fb);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DAMPING;
      csr_wdata <= dmp;
      @(posedge clock);
      csr_index <= CSR_FEEDBACK;
      csr_wdata <= fb;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Random samples: mostly full-range words, plus small values, mid magnitudes and
   // the extremes, so the sums wrap often and the quiet region is exercised too.
   function automatic logic signed [IO_W-1:0] pick_sample();
      logic signed [IO_W-1:0] v;
      int unsigned            sel;
      sel = $urandom_range(0, 99);
      v   = $urandom;
      if (sel < 20)
         v = $signed($urandom_range(0, 2000)) - 1000;
      else if (sel < 35)
         v = v >>> $urandom_range(1, 30);
      else if (sel < 45)
         v = EXTREME_SAMPLES[$urandom_range(0, NUM_EXTREMES - 1)];
      return v;
   endfunction

   initial begin
      logic [GAIN_W-1:0] dmp_g;
      logic [GAIN_W-1:0] fb_g;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed opening at the reset gains: every extreme sample, then the two
      // largest magnitudes back to back so the first wrapped sums appear early.
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      for (int i = 0; i < NUM_EXTREMES; i++)
         send_sample(EXTREME_SAMPLES[i]);
      for (int i = 0; i < 6; i++)
         send_sample(i[0] ? EXTREME_SAMPLES[6] : EXTREME_SAMPLES[5]);

      // Random segments. The combs only start returning data after 1116 samples, so
      // the run goes well past that point; the write addresses run past the end of
      // each delay line and wrap early on. The gains change at each segment boundary,
      // with the block drained and settled first.
      for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
         req_valid <= 1'b0;
         wait_for_drain();
         repeat (SETTLE_CYCLES) @(posedge clock);
         case (seg)
            0: begin dmp_g = 8'd255; fb_g = 8'd255; end
            1: begin dmp_g = 8'd0;   fb_g = 8'd0;   end
            2: begin dmp_g = 8'd255; fb_g = 8'd0;   end
            3: begin dmp_g = 8'd0;   fb_g = 8'd255; end
            default: begin
               dmp_g = GAIN_W'($urandom);
               fb_g  = GAIN_W'($urandom);
            end
         endcase
         write_gains(dmp_g, fb_g);

         // Sender fast and receiver slow, then the other way round, then full speed.
         if (seg < 2) begin
            send_idle_pct = 26;
            rsp_idle_pct  = 70;
         end else if (seg < 4) begin
            send_idle_pct = 70;
            rsp_idle_pct  = 26;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end

         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            // Long receiver stall while samples keep coming.
            if (seg == 0 && n == 100)
               hold_off_req <= 1'b1;
            // Sender stops until every predicted pair has come back.
            if (seg == 2 && n == 150) begin
               req_valid <= 1'b0;
               wait_for_drain();
            end
            send_sample(pick_sample());
         end
      end

      req_valid <= 1'b0;
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.pending_count() == 0)
         $display("PASS lowpass_feedback_comb_bank");
      else
         $display("FAIL lowpass_feedback_comb_bank");
      $finish;
   end

endmodule
